### sv/uart_lb_pkg.sv
// Package for the UART loopback register block.
// Holds the word types of both channels, the register addresses,
// and the operation and response codes. No dependencies.
`default_nettype none

package uart_lb_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Register addresses.
    localparam logic [7:0] ADDR_TXDATA = 8'h00;
    localparam logic [7:0] ADDR_RXDATA = 8'h04;
    localparam logic [7:0] ADDR_STATUS = 8'h08;

    // Response codes.
    localparam logic [1:0] RESP_OK       = 2'd0;
    localparam logic [1:0] RESP_ADDR_ERR = 2'd1;
    localparam logic [1:0] RESP_CMD_ERR  = 2'd2;

    // Status bit positions.
    localparam int STAT_RX_READY = 0;
    localparam int STAT_TX_READY = 1;
    localparam int STAT_TX_BUSY  = 2;

    // Configuration defaults and timer width.
    localparam logic [15:0] BIT_TICKS_RESET = 16'd16;
    localparam int          TIMER_W         = 20;

    // Input word: one tick, bus write or bus read.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] addr;
        logic [7:0] wdata;
    } in_word_t;

    // Result word: read data and response code.
    typedef struct packed {
        logic [7:0] rdata;
        logic [1:0] resp;
    } out_word_t;

endpackage

`default_nettype wire

### sv/uart_loopback_register_block.sv
// UART loopback register block: transmitter timing, receive FIFO and
// bus register decode in a single pass. Depends on uart_lb_pkg.
`default_nettype none

// Usage:
// Each input word is a tick (op 0), a bus write (op 1) or a bus read
// (op 2); every accepted word yields exactly one result word carrying
// rdata and resp. A write of address 0x00 while the transmitter is idle
// starts a byte that lasts ten times bit_ticks ticks; when it ends the
// byte lands in the receive FIFO (dropped if full). A read of 0x04 pops
// the FIFO, a read of 0x08 returns status.
// Result words are registered. Throughput: one word per cycle while
// the output is not stalled; the decode, timer and FIFO pointer
// update all happen between the input port and the result register,
// and the FIFO read lands directly in that register.
// When the receiver stalls, one more input word is taken into a skid
// register; after that in_stall rises until the output drains.
// Users write bit_ticks via cfg_write/cfg_data only while idle; unchecked.
// Reset clears the transmitter, the FIFO pointers, bit_ticks (to 16)
// and both result valid flags; FIFO storage and result data are not cleared.
module uart_loopback_register_block
    import uart_lb_pkg::*;
#(
    parameter int RX_DEPTH = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_write,
    input  wire logic [15:0] cfg_data,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_word_t  in_word,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_word_t      out_word
);

    localparam int PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int LVL_W = $clog2(RX_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RX_DEPTH - 1);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(RX_DEPTH);

    // State registers.
    logic [15:0]        bit_ticks_reg;
    logic [7:0]         tx_hold_reg, tx_hold_next;
    logic               tx_active_reg, tx_active_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic [7:0]         rx_mem [RX_DEPTH];

    // Output and skid registers.
    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_word_t out_reg;
    out_word_t skid_reg;

    // Handshake decode.
    logic accept;
    logic out_take;
    logic push;
    logic pop;
    logic load_out;
    logic load_skid;
    logic move_skid;
    out_word_t result;
    logic [TIMER_W-1:0] timer_dec;
    logic [TIMER_W-1:0] byte_len;

    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // Byte length is bit_ticks times ten, as two shifted adds.
    assign byte_len = {1'b0, bit_ticks_reg, 3'b000} + {3'b000, bit_ticks_reg, 1'b0};
    assign timer_dec = (timer_reg != '0) ? timer_reg - 1'b1 : '0;

    // Single-pass decode of the accepted word.
    always_comb
    begin
        tx_hold_next   = tx_hold_reg;
        tx_active_next = tx_active_reg;
        timer_next     = timer_reg;
        push           = 1'b0;
        pop            = 1'b0;
        result.rdata   = 8'h00;
        result.resp    = RESP_OK;
        case (in_word.op)
            OP_TICK:
            begin
                if (tx_active_reg)
                begin
                    timer_next = timer_dec;
                    if (timer_dec == '0)
                    begin
                        push           = 1'b1;
                        tx_active_next = 1'b0;
                    end
                end
            end
            OP_WRITE:
            begin
                if (in_word.addr != ADDR_TXDATA)
                begin
                    result.resp = RESP_ADDR_ERR;
                end
                else if (tx_active_reg)
                begin
                    result.resp = RESP_CMD_ERR;
                end
                else
                begin
                    tx_hold_next   = in_word.wdata;
                    tx_active_next = 1'b1;
                    timer_next     = byte_len;
                end
            end
            OP_READ:
            begin
                if (in_word.addr == ADDR_RXDATA)
                begin
                    pop = (level_reg != '0);
                end
                else if (in_word.addr == ADDR_STATUS)
                begin
                    result.rdata[STAT_RX_READY] = (level_reg != '0);
                    result.rdata[STAT_TX_READY] = !tx_active_reg;
                    result.rdata[STAT_TX_BUSY]  = tx_active_reg;
                end
                else
                begin
                    result.resp = RESP_ADDR_ERR;
                end
            end
            default:
            begin
                result.resp = RESP_CMD_ERR;
            end
        endcase
    end

    // FIFO pointer and level updates; a full FIFO drops the byte.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        level_next = level_reg;
        if (accept && push && (level_reg != LVL_FULL))
        begin
            tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
            level_next = level_reg + 1'b1;
        end
        else if (accept && pop)
        begin
            head_next  = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
            level_next = level_reg - 1'b1;
        end
    end

    // Result routing between the output register and the skid register.
    always_comb
    begin
        load_out        = 1'b0;
        load_skid       = 1'b0;
        move_skid       = 1'b0;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && !out_take)
        begin
            if (accept)
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            move_skid       = 1'b1;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end
        else
        begin
            load_out       = accept;
            out_valid_next = accept;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_ticks_reg  <= BIT_TICKS_RESET;
            tx_hold_reg    <= 8'h00;
            tx_active_reg  <= 1'b0;
            timer_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            level_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                bit_ticks_reg <= cfg_data;
            end
            if (accept)
            begin
                tx_hold_reg   <= tx_hold_next;
                tx_active_reg <= tx_active_next;
                timer_reg     <= timer_next;
            end
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            level_reg      <= level_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Receive FIFO storage write.
    always_ff @(posedge clk)
    begin
        if (accept && push && (level_reg != LVL_FULL))
        begin
            rx_mem[tail_reg] <= tx_hold_reg;
        end
    end

    // Result payload; a pop reads the FIFO straight into the register.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.resp  <= result.resp;
            out_reg.rdata <= pop ? rx_mem[head_reg] : result.rdata;
        end
        else if (move_skid)
        begin
            out_reg <= skid_reg;
        end
        if (load_skid)
        begin
            skid_reg.resp  <= result.resp;
            skid_reg.rdata <= pop ? rx_mem[head_reg] : result.rdata;
        end
    end

`ifndef SYNTH
    // The skid register only fills behind a stalled output word.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    // The FIFO level never exceeds its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_FULL)
        else $error("receive FIFO level above depth");

    // An idle transmitter has no ticks left on its timer.
    assert property (@(posedge clk) disable iff (!rst_n)
        !tx_active_reg |-> (timer_reg == '0))
        else $error("byte timer running while transmitter idle");

    // A pop lowers the level by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pop) |=> (level_reg == LVL_W'($past(level_reg) - 1'b1)))
        else $error("receive FIFO level not lowered by a pop");

    // Input is refused only while a skid word is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !accept) |-> (out_valid_reg && skid_valid_reg))
        else $error("input refused with free result space");
`endif

endmodule

`default_nettype wire
